// ===== rtl/vss_pkg.sv =====
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types, codes and defaults of the versioned sparse set.
// ----------------------------------------------------------------------------
package vss_pkg;

    localparam int MAX_ENTITIES_DEF  = 1024;
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int VERSION_WIDTH_DEF = 16;

    localparam int INDEX_W     = 10;
    localparam int VER_IN_W    = 16;
    localparam int DATA_IN_W   = 32;
    localparam int COUNT_OUT_W = 11;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_HAS    = 3'd3;
    localparam logic [2:0] OP_ENABLE = 3'd4;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_STALE  = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;
    localparam logic [1:0] STAT_RANGE  = 2'd3;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [INDEX_W-1:0]   entity_index;
        logic [VER_IN_W-1:0]  entity_version;
        logic [DATA_IN_W-1:0] component_data;
        logic                 enable_flag;
    } t_in;

    typedef struct packed {
        logic                   found;
        logic [DATA_IN_W-1:0]   data_out;
        logic                   enable_out;
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] live_count;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FETCH,
        S_EXEC,
        S_FIX
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic look;
        logic fetch;
        logic exec;
        logic fix;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic fix_need;
    } t_stat;

endpackage

// ===== rtl/vss_ctrl.sv =====
// ----------------------------------------------------------------------------
// vss_ctrl
// Sequencer: sparse clear pass, then lookup, fetch, execute and slot fix-up.
// ----------------------------------------------------------------------------
module vss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  vss_pkg::t_stat i_stat,
    output vss_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import vss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.fix_need ? S_FIX : S_IDLE;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/vss_datapath.sv =====
// ----------------------------------------------------------------------------
// vss_datapath
// Sparse and dense memories, entry count, operation decode and result register.
// ----------------------------------------------------------------------------
module vss_datapath #(
    parameter int MAX_ENTITIES  = vss_pkg::MAX_ENTITIES_DEF,
    parameter int DATA_WIDTH    = vss_pkg::DATA_WIDTH_DEF,
    parameter int VERSION_WIDTH = vss_pkg::VERSION_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vss_pkg::t_cmd  i_cmd,
    input  vss_pkg::t_in   i_in,
    input  logic           i_out_stall,
    output vss_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output vss_pkg::t_out  o_out
);
    import vss_pkg::*;

    localparam int PW       = $clog2(MAX_ENTITIES);
    localparam int CW       = $clog2(MAX_ENTITIES + 1);
    localparam int SW       = PW + 1;
    localparam int DATA_LSB = 1;
    localparam int VER_LSB  = DATA_LSB + DATA_WIDTH;
    localparam int IDX_LSB  = VER_LSB + VERSION_WIDTH;
    localparam int EW       = IDX_LSB + PW;

    t_in              r_in;
    logic [SW-1:0]    r_sparse_mem [MAX_ENTITIES];
    logic [EW-1:0]    r_dense_mem  [MAX_ENTITIES];
    logic [SW-1:0]    r_sp_rd;
    logic [EW-1:0]    r_dn_p;
    logic [EW-1:0]    r_dn_last;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    r_clr_addr;
    logic             r_out_valid;
    t_out             r_out;

    logic [CW-1:0]            n_count;
    logic [PW-1:0]            idx_pw;
    logic [VERSION_WIDTH-1:0] ver_v;
    logic [DATA_WIDTH-1:0]    data_d;
    logic                     sp_valid;
    logic [PW-1:0]            sp_pos;
    logic [PW-1:0]            last_pos;
    logic                     pos_live;
    logic                     in_range;
    logic                     hit;
    logic [PW-1:0]            dn_idx_p;
    logic [VERSION_WIDTH-1:0] dn_ver_p;
    logic [DATA_WIDTH-1:0]    dn_data_p;
    logic                     dn_en_p;
    logic [PW-1:0]            dn_idx_last;

    logic                     x_found;
    logic [DATA_WIDTH-1:0]    x_data;
    logic                     x_en;
    logic [1:0]               x_status;
    logic                     x_sp_we;
    logic [SW-1:0]            x_sp_wdata;
    logic                     x_dn_we;
    logic [PW-1:0]            x_dn_waddr;
    logic [EW-1:0]            x_dn_wdata;
    logic                     x_fix;

    logic                     sp_we;
    logic [PW-1:0]            sp_waddr;
    logic [SW-1:0]            sp_wdata;
    logic                     dn_we;
    logic                     out_free;

    assign idx_pw      = PW'(r_in.entity_index);
    assign ver_v       = VERSION_WIDTH'(r_in.entity_version);
    assign data_d      = DATA_WIDTH'(r_in.component_data);
    assign sp_valid    = r_sp_rd[PW];
    assign sp_pos      = r_sp_rd[PW-1:0];
    assign last_pos    = PW'(r_count - CW'(1));
    assign pos_live    = CW'(sp_pos) < r_count;
    assign in_range    = 32'(r_in.entity_index) < 32'(MAX_ENTITIES);
    assign dn_idx_p    = r_dn_p[IDX_LSB +: PW];
    assign dn_ver_p    = r_dn_p[VER_LSB +: VERSION_WIDTH];
    assign dn_data_p   = r_dn_p[DATA_LSB +: DATA_WIDTH];
    assign dn_en_p     = r_dn_p[0];
    assign dn_idx_last = r_dn_last[IDX_LSB +: PW];
    assign hit         = sp_valid && pos_live && (dn_idx_p == idx_pw) && (dn_ver_p == ver_v);

    always_comb begin
        x_found    = 1'b0;
        x_data     = '0;
        x_en       = 1'b0;
        x_status   = STAT_DONE;
        x_sp_we    = 1'b0;
        x_sp_wdata = '0;
        x_dn_we    = 1'b0;
        x_dn_waddr = sp_pos;
        x_dn_wdata = {idx_pw, ver_v, data_d, r_in.enable_flag};
        x_fix      = 1'b0;
        n_count    = r_count;
        if (!in_range) begin
            x_status = STAT_RANGE;
        end else begin
            unique case (r_in.opcode)
                OP_ADD: begin
                    if (!sp_valid || !pos_live) begin
                        if (r_count < CW'(MAX_ENTITIES)) begin
                            x_dn_we    = 1'b1;
                            x_dn_waddr = PW'(r_count);
                            x_sp_we    = 1'b1;
                            x_sp_wdata = {1'b1, PW'(r_count)};
                            n_count    = r_count + CW'(1);
                        end
                    end else if (dn_ver_p > ver_v) begin
                        x_status = STAT_STALE;
                    end else begin
                        x_dn_we = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!hit) begin
                        x_status = STAT_ABSENT;
                    end else begin
                        x_dn_we    = 1'b1;
                        x_dn_wdata = r_dn_last;
                        x_sp_we    = 1'b1;
                        x_sp_wdata = {1'b0, sp_pos};
                        n_count    = r_count - CW'(1);
                        x_fix      = sp_pos != last_pos;
                    end
                end
                OP_GET: begin
                    if (hit) begin
                        x_found = 1'b1;
                        x_data  = dn_data_p;
                        x_en    = dn_en_p;
                    end else begin
                        x_status = STAT_ABSENT;
                    end
                end
                OP_HAS: begin
                    if (hit) begin
                        x_found = 1'b1;
                    end else begin
                        x_status = STAT_ABSENT;
                    end
                end
                OP_ENABLE: begin
                    if (hit) begin
                        x_dn_we    = 1'b1;
                        x_dn_wdata = {r_dn_p[EW-1:1], r_in.enable_flag};
                    end else begin
                        x_status = STAT_ABSENT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sp_we    = 1'b0;
        sp_waddr = r_clr_addr;
        sp_wdata = '0;
        priority if (i_cmd.clear) begin
            sp_we = 1'b1;
        end else if (i_cmd.exec && x_sp_we) begin
            sp_we    = 1'b1;
            sp_waddr = idx_pw;
            sp_wdata = x_sp_wdata;
        end else if (i_cmd.fix) begin
            sp_we    = 1'b1;
            sp_waddr = dn_idx_last;
            sp_wdata = {1'b1, sp_pos};
        end else begin
            sp_we = 1'b0;
        end
    end

    assign dn_we    = i_cmd.exec && x_dn_we;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            r_sparse_mem[sp_waddr] <= sp_wdata;
        end
        if (i_cmd.look) begin
            r_sp_rd <= r_sparse_mem[idx_pw];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dn_we) begin
            r_dense_mem[x_dn_waddr] <= x_dn_wdata;
        end
        if (i_cmd.fetch) begin
            r_dn_p    <= r_dense_mem[sp_pos];
            r_dn_last <= r_dense_mem[last_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + PW'(1);
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.found      <= x_found;
            r_out.data_out   <= DATA_IN_W'(x_data);
            r_out.enable_out <= x_en;
            r_out.status     <= x_status;
            r_out.live_count <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_stat.clear_last = r_clr_addr == PW'(MAX_ENTITIES - 1);
    assign o_stat.out_free   = out_free;
    assign o_stat.fix_need   = x_fix;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

// ===== rtl/versioned_sparse_set.sv =====
// ----------------------------------------------------------------------------
// versioned_sparse_set
// Versioned sparse set mapping entity ids to a packed dense array of records.
// ----------------------------------------------------------------------------
// After reset the block sweeps the sparse table to invalid, one slot per cycle,
// with o_in_stall high until the last slot is cleared. Each item then passes
// from transfer to result through capture, sparse table read, dense array read
// (entry and last entry) and execute. A remove that moves the last entry into
// the hole adds a fix-up step for the second write to the single-port sparse
// table. The result sits in an output register, so a stalled result holds only
// the execute step; the next item can be taken while it waits.
module versioned_sparse_set #(
    parameter int MAX_ENTITIES  = vss_pkg::MAX_ENTITIES_DEF,
    parameter int DATA_WIDTH    = vss_pkg::DATA_WIDTH_DEF,
    parameter int VERSION_WIDTH = vss_pkg::VERSION_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  vss_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output vss_pkg::t_out o_out
);
    import vss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    vss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    vss_datapath #(
        .MAX_ENTITIES  (MAX_ENTITIES),
        .DATA_WIDTH    (DATA_WIDTH),
        .VERSION_WIDTH (VERSION_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/vss_checker.sv =====
// ----------------------------------------------------------------------------
// vss_checker
// Port-level checks of the versioned sparse set, bound to the top level.
// ----------------------------------------------------------------------------
module vss_checker #(
    parameter int MAX_ENTITIES = vss_pkg::MAX_ENTITIES_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input vss_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input vss_pkg::t_out o_out
);
    import vss_pkg::*;

    logic in_xfer;

    assign in_xfer = i_in_valid && !o_in_stall;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken again before item finished");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.live_count) <= 32'(MAX_ENTITIES))
        else $error("live count above capacity");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.data_out == '0 && !o_out.enable_out))
        else $error("record fields set without a hit");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.found) |-> (o_out.status == STAT_DONE))
        else $error("hit reported with error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind versioned_sparse_set vss_checker #(
    .MAX_ENTITIES (MAX_ENTITIES)
) u_vss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== sim/tb_versioned_sparse_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versioned_sparse_set
// Self-checking bench for the versioned sparse set. A scoreboard keeps its own
// copy of the sparse table and dense array, predicts the reply of every
// request at transfer, and checks replies in order, field by field. Stimulus
// is a directed opening, a mixed random phase on a small index pool, a fill
// of every index up to full capacity, and a remove-heavy random phase. Both
// sides idle at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_versioned_sparse_set;
    import vss_pkg::*;

    localparam int SLOTS           = MAX_ENTITIES_DEF;
    localparam int WATCHDOG_CYCLES = 6000;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_CODE_MAX  = 3'd7;

    class entity_table;
        bit                 slot_valid [SLOTS];
        int unsigned        slot_pos   [SLOTS];
        bit [INDEX_W-1:0]   id_index   [SLOTS];
        bit [VER_IN_W-1:0]  id_version [SLOTS];
        bit [DATA_IN_W-1:0] rec_data   [SLOTS];
        bit                 rec_enable [SLOTS];
        int unsigned        count;
        t_out               replies_due[$];
        int unsigned        requests, replies, hits, misses, stale_adds, peak, errors;

        function void store(int unsigned pos, t_in rq);
            id_index[pos]   = rq.entity_index;
            id_version[pos] = rq.entity_version;
            rec_data[pos]   = rq.component_data;
            rec_enable[pos] = rq.enable_flag;
        endfunction

        function void apply_request(t_in rq);
            t_out        rs;
            int unsigned idx, p, last, moved;
            bit          hit;
            rs  = '0;
            idx = rq.entity_index;
            requests++;
            if (idx >= SLOTS) begin
                rs.status = STAT_RANGE;
            end else begin
                p   = slot_pos[idx];
                hit = slot_valid[idx] && p < count && id_index[p] == idx
                      && id_version[p] == rq.entity_version;
                case (rq.opcode)
                    OP_ADD: begin
                        if (!slot_valid[idx] || p >= count) begin
                            if (count < SLOTS) begin
                                store(count, rq);
                                slot_valid[idx] = 1'b1;
                                slot_pos[idx]   = count;
                                count++;
                            end
                        end else if (id_version[p] > rq.entity_version) begin
                            rs.status = STAT_STALE;
                            stale_adds++;
                        end else begin
                            store(p, rq);
                        end
                    end
                    OP_REMOVE: begin
                        if (!hit) begin
                            rs.status = STAT_ABSENT;
                        end else begin
                            last            = count - 1;
                            moved           = id_index[last];
                            id_index[p]     = id_index[last];
                            id_version[p]   = id_version[last];
                            rec_data[p]     = rec_data[last];
                            rec_enable[p]   = rec_enable[last];
                            count           = last;
                            slot_valid[idx] = 1'b0;
                            if (p != last) begin
                                slot_pos[moved] = p;
                            end
                        end
                    end
                    OP_GET: begin
                        if (hit) begin
                            rs.found      = 1'b1;
                            rs.data_out   = rec_data[p];
                            rs.enable_out = rec_enable[p];
                        end else begin
                            rs.status = STAT_ABSENT;
                        end
                    end
                    OP_HAS: begin
                        if (hit) begin
                            rs.found = 1'b1;
                        end else begin
                            rs.status = STAT_ABSENT;
                        end
                    end
                    OP_ENABLE: begin
                        if (hit) begin
                            rec_enable[p] = rq.enable_flag;
                        end else begin
                            rs.status = STAT_ABSENT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (rs.found) hits++;
            if (rs.status == STAT_ABSENT) misses++;
            if (count > peak) peak = count;
            rs.live_count = COUNT_OUT_W'(count);
            replies_due = {replies_due, rs};
        endfunction

        function void compare(string field, logic [DATA_IN_W-1:0] want,
                              logic [DATA_IN_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_out got);
            t_out want;
            if (replies_due.size() == 0) begin
                $error("reply transfer with no request outstanding");
                errors++;
                return;
            end
            want = replies_due.pop_front();
            replies++;
            compare("found", want.found, got.found);
            compare("data_out", want.data_out, got.data_out);
            compare("enable_out", want.enable_out, got.enable_out);
            compare("status", want.status, got.status);
            compare("live_count", want.live_count, got.live_count);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    entity_table ledger = new();
    bit          steady;
    int unsigned sent;
    int unsigned idle_cycles;

    versioned_sparse_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin : monitor
        bit moved_any;
        moved_any = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                ledger.check_reply(o_out);
                moved_any = 1'b1;
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                ledger.apply_request(i_in);
                moved_any = 1'b1;
            end
            idle_cycles = moved_any ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : receiver
        int unsigned hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    function automatic logic [DATA_IN_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    function automatic t_in req(logic [2:0] op, int unsigned idx,
                                logic [DATA_IN_W-1:0] ver,
                                logic [DATA_IN_W-1:0] data, bit en);
        t_in rq;
        rq.opcode         = op;
        rq.entity_index   = INDEX_W'(idx);
        rq.entity_version = VER_IN_W'(ver);
        rq.component_data = data;
        rq.enable_flag    = en;
        return rq;
    endfunction

    function automatic logic [VER_IN_W-1:0] flip_bit(logic [VER_IN_W-1:0] ver);
        return ver ^ (VER_IN_W'(1) << $urandom_range(0, VER_IN_W - 1));
    endfunction

    function automatic t_in random_request(int unsigned index_hi);
        t_in         rq;
        int unsigned roll, p;
        rq   = req(OP_ADD, $urandom_range(0, index_hi), pick_word(), pick_word(),
                   1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 99);
        if (roll >= 95) begin
            rq.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_CODE_MAX));
        end else if (roll >= 85) begin
            rq.opcode       = 3'($urandom_range(OP_ADD, OP_CODE_MAX));
            rq.entity_index = INDEX_W'($urandom_range(0, SLOTS - 1));
        end else begin
            if (roll < 30)      rq.opcode = OP_ADD;
            else if (roll < 45) rq.opcode = OP_REMOVE;
            else if (roll < 60) rq.opcode = OP_GET;
            else if (roll < 70) rq.opcode = OP_HAS;
            else                rq.opcode = OP_ENABLE;
            if (ledger.count > 0 && $urandom_range(0, 3) != 0) begin
                p                 = $urandom_range(0, ledger.count - 1);
                rq.entity_index   = ledger.id_index[p];
                rq.entity_version = ledger.id_version[p];
                if ($urandom_range(0, 7) == 0) begin
                    rq.entity_version = flip_bit(rq.entity_version);
                end
            end
        end
        return rq;
    endfunction

    task automatic send_request(input t_in rq);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        sent++;
        steady = (sent % 320) >= 260;
    endtask

    // hold off new requests until every reply is back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (ledger.replies_due.size() != 0);
    endtask

    initial begin : stimulus
        t_in         rq;
        int unsigned order [SLOTS];
        int unsigned j, tmp, p;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(req(OP_HAS, 0, 0, 0, 0));
        send_request(req(OP_REMOVE, SLOTS - 1, 'hFFFF, 0, 0));
        send_request(req(OP_ADD, 0, 0, 0, 0));
        send_request(req(OP_ADD, SLOTS - 1, 'hFFFF, '1, 1));
        send_request(req(OP_GET, SLOTS - 1, 'hFFFF, 0, 0));
        send_request(req(OP_GET, 0, 0, '1, 1));
        send_request(req(OP_HAS, SLOTS - 1, 'hFFFE, 0, 0));
        send_request(req(OP_ADD, SLOTS - 1, 0, 'h1234_5678, 0));
        send_request(req(OP_ADD, 0, 5, 'hA5A5_A5A5, 1));
        send_request(req(OP_GET, 0, 0, 0, 0));
        send_request(req(OP_ENABLE, 0, 5, 0, 0));
        send_request(req(OP_GET, 0, 5, 0, 0));
        send_request(req(OP_ENABLE, 7, 0, 0, 1));
        send_request(req(OP_ADD, 512, 'h8000, 'h5A5A_5A5A, 1));
        send_request(req(OP_ENABLE, SLOTS - 1, 'hFFFF, 0, 1));
        send_request(req(OP_REMOVE, 0, 5, 0, 0));
        send_request(req(OP_GET, 512, 'h8000, 0, 0));
        send_request(req(OP_GET, SLOTS - 1, 'hFFFF, 0, 0));
        send_request(req(OP_REMOVE, 512, 'h8000, 0, 0));
        send_request(req(OP_REMOVE, SLOTS - 1, 'hFFFF, 0, 0));
        for (int op = OP_UNUSED_LO; op <= OP_CODE_MAX; op++) begin
            send_request(req(3'(op), $urandom_range(0, SLOTS - 1), pick_word(), pick_word(),
                             1'($urandom_range(0, 1))));
        end
        send_request(req(OP_HAS, 0, 0, 0, 0));
        settle();

        repeat (300) send_request(random_request(63));
        settle();

        // fill every index in shuffled order until the dense array is full
        for (int k = 0; k < SLOTS; k++) order[k] = k;
        for (int k = SLOTS - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        foreach (order[k]) begin
            rq = req(OP_ADD, order[k], pick_word(), pick_word(), 1'($urandom_range(0, 1)));
            if (ledger.slot_valid[order[k]]) begin
                rq.entity_version = ledger.id_version[ledger.slot_pos[order[k]]];
                if ($urandom_range(0, 3) == 0) begin
                    rq.entity_version = flip_bit(rq.entity_version);
                end
            end
            send_request(rq);
        end
        settle();

        repeat (220) begin
            if (ledger.count > 0 && $urandom_range(0, 9) < 6) begin
                p  = $urandom_range(0, ledger.count - 1);
                rq = req(OP_REMOVE, ledger.id_index[p], DATA_IN_W'(ledger.id_version[p]),
                         pick_word(), 1'($urandom_range(0, 1)));
            end else begin
                rq = random_request(SLOTS - 1);
            end
            send_request(rq);
        end

        settle();
        repeat (10) @(negedge i_clk);
        $display("Ran %0d requests: %0d lookup hits, %0d misses, %0d stale adds, %0d replies",
                 ledger.requests, ledger.hits, ledger.misses, ledger.stale_adds,
                 ledger.replies);
        $display("Dense array peaked at %0d of %0d entries; %0d field mismatches",
                 ledger.peak, SLOTS, ledger.errors);
        if (ledger.errors == 0 && ledger.replies_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vss_pkg.sv
rtl/vss_ctrl.sv
rtl/vss_datapath.sv
rtl/versioned_sparse_set.sv
rtl/vss_checker.sv
sim/tb_versioned_sparse_set.sv
